@@ hdl/gnrp_pkg.sv @@
// Shared types and constants of the grid nearest-neighbor resample packer.
`default_nettype none
package gnrp_pkg;

	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PACK_MODE  = 3'd4;

	localparam logic [7:0] VIS_NONE    = 8'd0;
	localparam logic [7:0] VIS_FOGGED  = 8'd1;
	localparam logic [7:0] VIS_VISIBLE = 8'd2;

	localparam logic [2:0] LAST_BIT = 3'd7;

	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_EMIT,
		KIND_REWIND
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_CELL,
		S_YMUL,
		S_YDIV,
		S_XMUL,
		S_XDIV,
		S_IDX,
		S_RD,
		S_USE,
		S_OUT
	} state_t;

endpackage
`default_nettype wire

@@ hdl/grid_nearest_resample_packer.sv @@
// Top level of the grid nearest-neighbor resample packer.
// A load beat (tuser kind 0) stores one source cell in raster order; a rewind is kind 2.
// An emit beat (kind 1) walks destination cells through one shared divider that forms
// one quotient bit per cycle over NUM_W = 2 * clog2(MAX_DIM + 1) + 1 bits (19 at default).
// Each cell runs it for the column mapping. The first cell of each destination row, and
// the first after a rewind or a configuration write, runs it first for the row mapping.
// An emit also passes through a setup step, waits until the output register is free to
// pass its byte there, and goes back to idle. A bit-mode emit handles up to eight cells.
// An emit that finds the image finished gives no byte. The block takes no new beat while
// an emit is at work; a finished byte waits in the output register without holding up
// input.
// The source grid RAM is not cleared; only loaded cells may be read back.
`default_nettype none
module grid_nearest_resample_packer
	import gnrp_pkg::*;
#(
	parameter int MAX_DIM   = 256,
	parameter int SRC_CELLS = 65536
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,   // [0] seen_flag, [1] explored_flag
	input  wire logic [1:0]           s_tuser,   // [1:0] kind
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [7:0]           m_tdata,   // [7:0] out_byte
	output logic                      m_tlast,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int EW     = (DIM_W > CFG_W) ? DIM_W : CFG_W;
	localparam int NUM_W  = 2 * DIM_W + 1;
	localparam int DEN_W  = DIM_W + 1;
	localparam int IDX_W  = 2 * DIM_W;
	localparam int ADDR_W = $clog2(SRC_CELLS);
	localparam int CUR_W  = $clog2(SRC_CELLS + 1);
	localparam int CMP_W  = (IDX_W > CUR_W) ? IDX_W : CUR_W;

	localparam logic [CUR_W-1:0] CUR_LIM = CUR_W'(SRC_CELLS);
	localparam logic [CMP_W-1:0] IDX_LIM = CMP_W'(SRC_CELLS);

	function automatic logic [DIM_W-1:0] dim_eff(input logic [CFG_W-1:0] v);
		logic [EW-1:0] w;
		w = EW'(v);
		if (v == '0) begin
			return DIM_W'(1);
		end
		if (w > EW'(MAX_DIM)) begin
			return DIM_W'(MAX_DIM);
		end
		return DIM_W'(w);
	endfunction

	state_t state_q, state_d;

	logic [DIM_W-1:0] sw_q, sh_q, dw_q, dh_q;
	logic             mode_q;
	logic [CUR_W-1:0] cursor_q;
	logic [DIM_W-1:0] col_q, row_q;
	logic             done_img_q;
	logic             sy_ok_q;
	logic [DIM_W-1:0] sx_q, sy_q;
	logic [IDX_W-1:0] idx_q;
	logic             oob_q;
	logic [7:0]       bits_q;
	logic [2:0]       bcnt_q;
	logic [7:0]       res_byte_q;
	logic             res_last_q;
	logic             m_tvalid_q;
	logic [7:0]       m_tdata_q;
	logic             m_tlast_q;

	logic             in_fire;
	kind_t            kind;
	logic             ram_we;
	logic [1:0]       ram_rdata;
	logic             div_start, div_done;
	logic [NUM_W-1:0] div_num, div_quot;
	logic [DEN_W-1:0] div_den;
	logic [NUM_W-1:0] q_clamp_lim;
	logic [DIM_W-1:0] coord;
	logic             col_wrap;
	logic [DIM_W-1:0] row_w;
	logic [DIM_W-1:0] col_inc;
	logic             adv_wrap;
	logic [DIM_W-1:0] row_adv;
	logic             adv_last;
	logic [1:0]       flags;
	logic [IDX_W-1:0] idx_sum;
	logic             out_free;
	logic             finish;
	logic [7:0]       bits_d;

	assign s_tready  = state_q == S_IDLE;
	assign cfg_ready = 1'b1;
	assign in_fire   = s_tvalid && s_tready;
	assign kind      = kind_t'(s_tuser);
	assign out_free  = !m_tvalid_q || m_tready;

	assign ram_we = in_fire && kind == KIND_LOAD && cursor_q < CUR_LIM;

	gnrp_ram #(
		.WIDTH(2),
		.DEPTH(SRC_CELLS)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ADDR_W'(cursor_q)),
		.wdata(s_tdata[1:0]),
		.raddr(ADDR_W'(idx_q)),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (state_q == S_YMUL) begin
			div_num = NUM_W'({row_q, 1'b1}) * NUM_W'(sh_q);
			div_den = {dh_q, 1'b0};
		end else begin
			div_num = NUM_W'({col_q, 1'b1}) * NUM_W'(sw_q);
			div_den = {dw_q, 1'b0};
		end
	end

	gnrp_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_comb begin
		if (state_q == S_YDIV) begin
			q_clamp_lim = NUM_W'(sh_q - DIM_W'(1));
		end else begin
			q_clamp_lim = NUM_W'(sw_q - DIM_W'(1));
		end
		if (div_quot > q_clamp_lim) begin
			coord = DIM_W'(q_clamp_lim);
		end else begin
			coord = DIM_W'(div_quot);
		end
	end

	assign col_wrap = col_q >= dw_q;
	assign row_w    = col_wrap ? row_q + DIM_W'(1) : row_q;
	assign col_inc  = col_q + DIM_W'(1);
	assign adv_wrap = col_inc >= dw_q;
	assign row_adv  = adv_wrap ? row_q + DIM_W'(1) : row_q;
	assign adv_last = row_adv >= dh_q;
	assign flags    = oob_q ? 2'b00 : ram_rdata;
	assign idx_sum  = IDX_W'(sy_q) * IDX_W'(sw_q) + IDX_W'(sx_q);

	always_comb begin
		bits_d = bits_q;
		bits_d[LAST_BIT - bcnt_q] = flags[0];
	end

	assign finish = !mode_q || bcnt_q == LAST_BIT || adv_last;

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && kind == KIND_EMIT && !done_img_q) begin
					state_d = S_START;
				end
			end
			S_START: begin
				if (row_w >= dh_q) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_CELL;
				end
			end
			S_CELL: begin
				state_d = sy_ok_q ? S_XMUL : S_YMUL;
			end
			S_YMUL: begin
				div_start = 1'b1;
				state_d   = S_YDIV;
			end
			S_YDIV: begin
				if (div_done) begin
					state_d = S_XMUL;
				end
			end
			S_XMUL: begin
				div_start = 1'b1;
				state_d   = S_XDIV;
			end
			S_XDIV: begin
				if (div_done) begin
					state_d = S_IDX;
				end
			end
			S_IDX: begin
				state_d = S_RD;
			end
			S_RD: begin
				state_d = S_USE;
			end
			S_USE: begin
				state_d = finish ? S_OUT : S_CELL;
			end
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q       <= DIM_W'(1);
			sh_q       <= DIM_W'(1);
			dw_q       <= DIM_W'(1);
			dh_q       <= DIM_W'(1);
			mode_q     <= 1'b0;
			cursor_q   <= '0;
			col_q      <= '0;
			row_q      <= '0;
			done_img_q <= 1'b0;
			sy_ok_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				sy_ok_q <= 1'b0;
				unique case (cfg_index)
					REG_SRC_WIDTH:  sw_q   <= dim_eff(cfg_data);
					REG_SRC_HEIGHT: sh_q   <= dim_eff(cfg_data);
					REG_DST_WIDTH:  dw_q   <= dim_eff(cfg_data);
					REG_DST_HEIGHT: dh_q   <= dim_eff(cfg_data);
					REG_PACK_MODE:  mode_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (ram_we) begin
						cursor_q <= cursor_q + CUR_W'(1);
					end
					if (in_fire && kind == KIND_REWIND) begin
						cursor_q   <= '0;
						col_q      <= '0;
						row_q      <= '0;
						done_img_q <= 1'b0;
						sy_ok_q    <= 1'b0;
					end
				end
				S_START: begin
					if (col_wrap) begin
						col_q   <= '0;
						row_q   <= row_w;
						sy_ok_q <= 1'b0;
					end
					if (row_w >= dh_q) begin
						done_img_q <= 1'b1;
					end
				end
				S_YDIV: begin
					if (div_done) begin
						sy_ok_q <= 1'b1;
					end
				end
				S_USE: begin
					if (adv_wrap) begin
						col_q   <= '0;
						row_q   <= row_adv;
						sy_ok_q <= 1'b0;
					end else begin
						col_q <= col_inc;
					end
				end
				S_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						if (res_last_q) begin
							done_img_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_START: begin
				bits_q <= '0;
				bcnt_q <= '0;
			end
			S_YDIV: begin
				if (div_done) begin
					sy_q <= coord;
				end
			end
			S_XDIV: begin
				if (div_done) begin
					sx_q <= coord;
				end
			end
			S_IDX: begin
				idx_q <= idx_sum;
				oob_q <= CMP_W'(idx_sum) >= IDX_LIM;
			end
			S_USE: begin
				bits_q     <= bits_d;
				bcnt_q     <= bcnt_q + 3'd1;
				res_last_q <= adv_last;
				if (mode_q) begin
					res_byte_q <= bits_d;
				end else if (flags[0]) begin
					res_byte_q <= VIS_VISIBLE;
				end else if (flags[1]) begin
					res_byte_q <= VIS_FOGGED;
				end else begin
					res_byte_q <= VIS_NONE;
				end
			end
			S_OUT: begin
				if (out_free) begin
					m_tdata_q <= res_byte_q;
					m_tlast_q <= res_last_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_XDIV || state_q == S_YDIV))
		else $error("divider finished outside a wait state");

	a_row_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_USE |-> row_q < dh_q)
		else $error("destination row past the image during a cell");

	a_coord_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDX |-> (sx_q < sw_q && sy_q < sh_q))
		else $error("mapped source coordinate outside the source grid");

endmodule
`default_nettype wire

@@ hdl/gnrp_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module gnrp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ hdl/gnrp_div.sv @@
// Restoring divider that forms one quotient bit per cycle after latching a product.
`default_nettype none
module gnrp_div #(
	parameter int NUM_W = 19,
	parameter int DEN_W = 10
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic      [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] n_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, n_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			n_q <= {n_q[NUM_W-2:0], fits};
			if (fits) begin
				rem_q <= DEN_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[DEN_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign quot = n_q;

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the grid nearest-neighbor resample packer.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import gnrp_pkg::*;

	localparam int DIM_MAX = 256;
	localparam int CELL_COUNT = 65536;
	localparam int ITEM_TARGET = 650;
	localparam int SETTLE_CYCLES = 500;
	localparam int STALL_LIMIT = 4000;
	localparam logic [1:0] KIND_RESERVED = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} image_byte_t;

	class grid_mirror;
		logic [1:0]  cells [CELL_COUNT];
		int unsigned load_pos;
		int unsigned col;
		int unsigned row;
		bit          finished;
		logic [8:0]  reg_sw;
		logic [8:0]  reg_sh;
		logic [8:0]  reg_dw;
		logic [8:0]  reg_dh;
		logic        bit_mode;
		image_byte_t pending [$];
		int          mismatches;

		function new();
			reg_sw = 9'd1;
			reg_sh = 9'd1;
			reg_dw = 9'd1;
			reg_dh = 9'd1;
			bit_mode = 1'b0;
			load_pos = 0;
			col = 0;
			row = 0;
			finished = 1'b0;
			mismatches = 0;
		endfunction

		function int unsigned eff_dim(logic [8:0] v);
			if (v == 9'd0) return 1;
			if (v > DIM_MAX) return DIM_MAX;
			return v;
		endfunction

		function int unsigned nearest(int unsigned d, int unsigned s, int unsigned n);
			int unsigned q;
			q = ((2 * d + 1) * s) / (2 * n);
			return (q > s - 1) ? s - 1 : q;
		endfunction

		function logic [1:0] flags_here(int unsigned sw, int unsigned sh,
				int unsigned dw, int unsigned dh);
			int unsigned idx;
			idx = nearest(row, sh, dh) * sw + nearest(col, sw, dw);
			return (idx >= CELL_COUNT) ? 2'b00 : cells[idx];
		endfunction

		function void step_cell(int unsigned dw);
			col++;
			if (col >= dw) begin
				col = 0;
				row++;
			end
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_SRC_WIDTH: reg_sw = v;
				REG_SRC_HEIGHT: reg_sh = v;
				REG_DST_WIDTH: reg_dw = v;
				REG_DST_HEIGHT: reg_dh = v;
				REG_PACK_MODE: bit_mode = v[0];
				default: ;
			endcase
		endfunction

		function void take_beat(logic [1:0] k, logic seen, logic expl);
			int unsigned sw, sh, dw, dh;
			logic [1:0]  f;
			logic [7:0]  acc;
			image_byte_t b;
			if (k == KIND_LOAD) begin
				if (load_pos < CELL_COUNT) begin
					cells[load_pos] = {expl, seen};
					load_pos++;
				end
				return;
			end
			if (k == KIND_REWIND) begin
				load_pos = 0;
				col = 0;
				row = 0;
				finished = 1'b0;
				return;
			end
			if (k != KIND_EMIT || finished) return;
			sw = eff_dim(reg_sw);
			sh = eff_dim(reg_sh);
			dw = eff_dim(reg_dw);
			dh = eff_dim(reg_dh);
			if (col >= dw) begin
				col = 0;
				row++;
			end
			if (row >= dh) begin
				finished = 1'b1;
				return;
			end
			acc = 8'd0;
			if (!bit_mode) begin
				f = flags_here(sw, sh, dw, dh);
				acc = f[0] ? VIS_VISIBLE : (f[1] ? VIS_FOGGED : VIS_NONE);
				step_cell(dw);
			end else begin
				for (int i = 0; i < 8; i++) begin
					if (row >= dh) break;
					f = flags_here(sw, sh, dw, dh);
					if (f[0]) acc[LAST_BIT - i] = 1'b1;
					step_cell(dw);
				end
			end
			finished = row >= dh;
			b.data = acc;
			b.last = finished;
			pending.push_back(b);
		endfunction

		function void match_byte(logic [7:0] data, logic last);
			image_byte_t b;
			if (pending.size() == 0) begin
				$display("%0t: unexpected byte: expected none, actual %h last %b",
					$time, data, last);
				mismatches++;
				return;
			end
			b = pending.pop_front();
			if (data !== b.data) begin
				$display("%0t: byte mismatch: expected %h, actual %h", $time, b.data, data);
				mismatches++;
			end
			if (last !== b.last) begin
				$display("%0t: last mismatch: expected %b, actual %b", $time, b.last, last);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = 8'd0;
	logic [1:0]           s_tuser = 2'd0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [7:0]           m_tdata;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	grid_mirror  mirror = new();
	int unsigned load_pos = 0;
	int unsigned filled = 0;
	int unsigned sent = 0;
	int unsigned img_cells = 1;
	int unsigned img_bytes = 1;
	bit          idle_on = 1'b1;
	int          stall_left = 0;
	int          idle_cycles = 0;

	grid_nearest_resample_packer #(
		.MAX_DIM(DIM_MAX),
		.SRC_CELLS(CELL_COUNT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (stall_left == 1) begin
			stall_left <= 0;
			m_tready <= 1'b1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(1, 10);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) mirror.take_beat(s_tuser, s_tdata[0], s_tdata[1]);
			if (cfg_valid && cfg_ready) mirror.set_reg(cfg_index, cfg_data);
			if (m_tvalid && m_tready) mirror.match_byte(m_tdata, m_tlast);
			if ((s_tvalid && s_tready) || (cfg_valid && cfg_ready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		while (idle_cycles < STALL_LIMIT) @(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_beat(input logic [1:0] k, input logic seen, input logic expl);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= {6'd0, expl, seen};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (k == KIND_LOAD) begin
			if (load_pos < CELL_COUNT) load_pos++;
			if (load_pos > filled) filled = load_pos;
		end else if (k == KIND_REWIND) begin
			load_pos = 0;
		end
		if (k != KIND_RESERVED) sent++;
	endtask

	task automatic load_run(input int unsigned n);
		repeat (n) send_beat(KIND_LOAD, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	task automatic emit_run(input int unsigned n, input bit rough);
		repeat (n) begin
			if ($urandom_range(0, 19) == 0)
				send_beat(KIND_RESERVED, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			if (rough && $urandom_range(0, 24) == 0)
				send_beat(KIND_REWIND, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			if (rough && $urandom_range(0, 9) == 0) load_run($urandom_range(1, 4));
			send_beat(KIND_EMIT, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic write_regs(input logic [8:0] sw, input logic [8:0] sh,
			input logic [8:0] dw, input logic [8:0] dh, input logic mode);
		logic [8:0] vals [5];
		vals[0] = sw;
		vals[1] = sh;
		vals[2] = dw;
		vals[3] = dh;
		vals[4] = {8'($urandom_range(0, 255)), mode};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= REG_SRC_WIDTH + 3'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		if ($urandom_range(0, 3) == 0) begin
			cfg_index <= REG_PACK_MODE + 3'($urandom_range(1, 3));
			cfg_data <= 9'($urandom_range(0, 511));
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		img_cells = mirror.eff_dim(sw) * mirror.eff_dim(sh);
		img_bytes = mirror.eff_dim(dw) * mirror.eff_dim(dh);
		if (mode) img_bytes = (img_bytes + 7) / 8;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (mirror.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [8:0]  sw_v, sh_v, dw_v, dh_v;
		logic        mode_v;
		int unsigned shape;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: one cell in, one cell out, visibility codes; then bit mode.
		send_beat(KIND_LOAD, 1'b1, 1'b0);
		send_beat(KIND_EMIT, 1'b0, 1'b0);
		send_beat(KIND_EMIT, 1'b1, 1'b1);
		send_beat(KIND_RESERVED, 1'b1, 1'b1);
		send_beat(KIND_REWIND, 1'b0, 1'b0);
		send_beat(KIND_LOAD, 1'b0, 1'b1);
		send_beat(KIND_EMIT, 1'b0, 1'b0);
		send_beat(KIND_REWIND, 1'b1, 1'b0);
		send_beat(KIND_LOAD, 1'b0, 1'b0);
		send_beat(KIND_EMIT, 1'b0, 1'b0);
		send_beat(KIND_REWIND, 1'b0, 1'b1);
		send_beat(KIND_LOAD, 1'b1, 1'b1);
		settle();
		write_regs(9'd1, 9'd1, 9'd1, 9'd1, 1'b1);
		send_beat(KIND_REWIND, 1'b1, 1'b1);
		send_beat(KIND_EMIT, 1'b1, 1'b0);
		settle();

		// Shrinking the image mid-way ends it without a result.
		write_regs(9'd2, 9'd2, 9'd4, 9'd4, 1'b0);
		send_beat(KIND_REWIND, 1'b0, 1'b0);
		load_run(4);
		emit_run(5, 1'b0);
		settle();
		write_regs(9'd2, 9'd2, 9'd0, 9'd0, 1'b1);
		send_beat(KIND_EMIT, 1'b0, 1'b0);
		settle();

		// The widest and tallest images, with saturated destination sizes.
		write_regs(9'd8, 9'd2, 9'd511, 9'd1, 1'b1);
		send_beat(KIND_REWIND, 1'b0, 1'b0);
		load_run(img_cells + 3);
		emit_run(img_bytes + 1, 1'b0);
		settle();
		write_regs(9'd2, 9'd8, 9'd1, 9'd300, 1'b1);
		send_beat(KIND_REWIND, 1'b0, 1'b0);
		emit_run(img_bytes + 1, 1'b0);
		settle();

		while (sent < ITEM_TARGET) begin
			idle_on = (sent < ITEM_TARGET * 85 / 100) && ($urandom_range(0, 3) != 0);
			sw_v = 9'($urandom_range(1, 16));
			sh_v = 9'($urandom_range(1, 16));
			dw_v = 9'($urandom_range(1, 12));
			dh_v = 9'($urandom_range(1, 12));
			mode_v = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 9))
				0: begin
					if ($urandom_range(0, 1)) begin
						dw_v = 9'($urandom_range(200, 511));
						dh_v = 9'($urandom_range(0, 1));
					end else begin
						dh_v = 9'($urandom_range(200, 511));
						dw_v = 9'($urandom_range(0, 1));
					end
				end
				1: begin
					sw_v = 9'($urandom_range(257, 511));
					sh_v = 9'd0;
				end
				2: begin
					sw_v = 9'd0;
					dh_v = 9'd0;
					dw_v = 9'($urandom_range(0, 3));
				end
				default: ;
			endcase
			write_regs(sw_v, sh_v, dw_v, dh_v, mode_v);
			shape = $urandom_range(0, 9);
			if (img_cells > filled) shape = 0;
			if (shape == 7) begin
				emit_run($urandom_range(1, 12), 1'b0);
			end else if (shape == 8) begin
				send_beat(KIND_REWIND, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				load_run($urandom_range(0, img_cells));
				emit_run($urandom_range(1, img_bytes + 2), 1'b1);
			end else if (shape == 9) begin
				repeat ($urandom_range(10, 30))
					send_beat(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
			end else begin
				send_beat(KIND_REWIND, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				load_run(img_cells + $urandom_range(0, 3));
				emit_run(img_bytes + $urandom_range(0, 2), 1'b0);
			end
			settle();
		end

		if (mirror.mismatches == 0 && mirror.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ grid_nearest_resample_packer.f @@
hdl/gnrp_pkg.sv
hdl/gnrp_ram.sv
hdl/gnrp_div.sv
hdl/grid_nearest_resample_packer.sv
tb/testbench.sv
